### rtl/xtis_pkg.sv
// shared types, widths and codes for the x-ray tube interlock sequencer
// no dependencies; every rtl file refers to it by scoped names
package xtis_pkg;

   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 3;
   localparam int REQ_KV_W  = 10;
   localparam int KV_W      = 8;
   localparam int CUR_W     = 10;
   localparam int DUR_W     = 32;
   localparam int RAMP_W    = 10;
   localparam int PCT_W     = 8;
   localparam int BLINK_W   = 9;
   localparam int METER_W   = 12;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int BLINK_PERIOD = 500;
   localparam int BLINK_ON     = 250;
   localparam int PCT_SCALE    = 100;

   // meter = present_kv * METER_MAX / FULL_SCALE_KV via a scaled reciprocal
   localparam int    METER_MAX     = 4095;
   localparam int    FULL_SCALE_KV = 150;
   localparam int    METER_SHIFT   = 16;
   localparam longint METER_RECIP  =
      ((longint'(METER_MAX) << METER_SHIFT) + FULL_SCALE_KV - 1) / FULL_SCALE_KV;
   localparam int    RECIP_W       = $clog2(METER_RECIP + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_TICK,
      FN_SET_VOLT,
      FN_SET_CUR,
      FN_START,
      FN_STOP,
      FN_ESTOP,
      FN_CLR_FAULT,
      FN_MEASURE
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_VOLT_RANGE,
      ST_CUR_RANGE,
      ST_FAULTED,
      ST_VOLT_LOW,
      ST_WARN,
      ST_TRIP,
      ST_TIMED_STOP
   } status_type;

   typedef enum logic [3:0] {
      CMD_TICK,
      CMD_SET_VOLT,
      CMD_VOLT_REJECT,
      CMD_SET_CUR,
      CMD_CUR_REJECT,
      CMD_START,
      CMD_STOP,
      CMD_ESTOP,
      CMD_CLR_FAULT,
      CMD_MEASURE
   } cmd_type;

   typedef enum logic [2:0] {
      REG_MIN_KV,
      REG_MAX_KV,
      REG_MIN_UA,
      REG_MAX_UA,
      REG_RAMP_MS,
      REG_WARN_PCT,
      REG_TRIP_PCT
   } reg_type;

   typedef struct packed {
      logic [KV_W-1:0]   min_kv;
      logic [KV_W-1:0]   max_kv;
      logic [CUR_W-1:0]  min_ua;
      logic [CUR_W-1:0]  max_ua;
      logic [RAMP_W-1:0] ramp_ms;
      logic [PCT_W-1:0]  warn_pct;
      logic [PCT_W-1:0]  trip_pct;
   } cfg_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [KV_W-1:0]   kv;
      logic [CUR_W-1:0]  ua;
      logic              fil_on;
      logic [DUR_W-1:0]  dur;
      logic [CUR_W-1:0]  meas;
   } item_type;

endpackage

### rtl/xtis_csr.sv
// configuration registers behind an apb-style port
// depends on xtis_pkg
module xtis_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xtis_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xtis_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xtis_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output xtis_pkg::cfg_type                cfg
);

   xtis_pkg::cfg_type cfg_ff, cfg_in;
   xtis_pkg::reg_type idx;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign idx        = xtis_pkg::reg_type'(csr_paddr[xtis_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            xtis_pkg::REG_MIN_KV:   cfg_in.min_kv   = csr_pwdata[xtis_pkg::KV_W-1:0];
            xtis_pkg::REG_MAX_KV:   cfg_in.max_kv   = csr_pwdata[xtis_pkg::KV_W-1:0];
            xtis_pkg::REG_MIN_UA:   cfg_in.min_ua   = csr_pwdata[xtis_pkg::CUR_W-1:0];
            xtis_pkg::REG_MAX_UA:   cfg_in.max_ua   = csr_pwdata[xtis_pkg::CUR_W-1:0];
            xtis_pkg::REG_RAMP_MS:  cfg_in.ramp_ms  = csr_pwdata[xtis_pkg::RAMP_W-1:0];
            xtis_pkg::REG_WARN_PCT: cfg_in.warn_pct = csr_pwdata[xtis_pkg::PCT_W-1:0];
            xtis_pkg::REG_TRIP_PCT: cfg_in.trip_pct = csr_pwdata[xtis_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         xtis_pkg::REG_MIN_KV:   csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.min_kv);
         xtis_pkg::REG_MAX_KV:   csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.max_kv);
         xtis_pkg::REG_MIN_UA:   csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.min_ua);
         xtis_pkg::REG_MAX_UA:   csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.max_ua);
         xtis_pkg::REG_RAMP_MS:  csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.ramp_ms);
         xtis_pkg::REG_WARN_PCT: csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.warn_pct);
         xtis_pkg::REG_TRIP_PCT: csr_prdata = xtis_pkg::CSR_DATA_W'(cfg_ff.trip_pct);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_kv   <= xtis_pkg::KV_W'(10);
         cfg_ff.max_kv   <= xtis_pkg::KV_W'(150);
         cfg_ff.min_ua   <= xtis_pkg::CUR_W'(10);
         cfg_ff.max_ua   <= xtis_pkg::CUR_W'(400);
         cfg_ff.ramp_ms  <= xtis_pkg::RAMP_W'(10);
         cfg_ff.warn_pct <= xtis_pkg::PCT_W'(115);
         cfg_ff.trip_pct <= xtis_pkg::PCT_W'(125);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/xtis_front.sv
// front end: accepts requests and classifies them, with range checks on set commands
// depends on xtis_pkg
module xtis_front (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [xtis_pkg::FUNC_W-1:0]     req_func,
   input  logic [xtis_pkg::REQ_KV_W-1:0]   req_kilovolts,
   input  logic [xtis_pkg::CUR_W-1:0]      req_microamps,
   input  logic [xtis_pkg::DUR_W-1:0]      req_duration_ms,
   input  logic [xtis_pkg::CUR_W-1:0]      req_measured_microamps,
   input  xtis_pkg::cfg_type               cfg,
   input  logic                            q_full,
   output logic                            q_push,
   output xtis_pkg::item_type              q_item
);

   logic volt_bad;
   logic cur_bad;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   assign volt_bad = (req_kilovolts < xtis_pkg::REQ_KV_W'(cfg.min_kv)) |
                     (req_kilovolts > xtis_pkg::REQ_KV_W'(cfg.max_kv));
   assign cur_bad  = (req_microamps < cfg.min_ua) | (req_microamps > cfg.max_ua);

   always_comb begin
      q_item.kv     = req_kilovolts[xtis_pkg::KV_W-1:0];
      q_item.ua     = req_microamps;
      q_item.fil_on = req_microamps > cfg.min_ua;
      q_item.dur    = req_duration_ms;
      q_item.meas   = req_measured_microamps;
      case (xtis_pkg::func_type'(req_func))
         xtis_pkg::FN_TICK:      q_item.cmd = xtis_pkg::CMD_TICK;
         xtis_pkg::FN_SET_VOLT:  q_item.cmd = volt_bad ? xtis_pkg::CMD_VOLT_REJECT
                                                       : xtis_pkg::CMD_SET_VOLT;
         xtis_pkg::FN_SET_CUR:   q_item.cmd = cur_bad ? xtis_pkg::CMD_CUR_REJECT
                                                      : xtis_pkg::CMD_SET_CUR;
         xtis_pkg::FN_START:     q_item.cmd = xtis_pkg::CMD_START;
         xtis_pkg::FN_STOP:      q_item.cmd = xtis_pkg::CMD_STOP;
         xtis_pkg::FN_ESTOP:     q_item.cmd = xtis_pkg::CMD_ESTOP;
         xtis_pkg::FN_CLR_FAULT: q_item.cmd = xtis_pkg::CMD_CLR_FAULT;
         xtis_pkg::FN_MEASURE:   q_item.cmd = xtis_pkg::CMD_MEASURE;
         default:                q_item.cmd = xtis_pkg::CMD_TICK;
      endcase
   end

endmodule

### rtl/xtis_queue.sv
// two-entry queue of classified commands between front and back end
// depends on xtis_pkg
module xtis_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xtis_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output xtis_pkg::item_type  pop_item,
   output logic                empty
);

   xtis_pkg::item_type                mem_ff [xtis_pkg::Q_DEPTH];
   logic [xtis_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [xtis_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [xtis_pkg::Q_CNT_W-1:0]      count_ff, count_in;

   assign full     = count_ff == xtis_pkg::Q_CNT_W'(xtis_pkg::Q_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/xtis_back.sv
// back end: runs commands on the tube state and holds the result register
// depends on xtis_pkg
module xtis_back (
   input  logic                              clock,
   input  logic                              reset,
   input  xtis_pkg::cfg_type                 cfg,
   input  logic                              q_empty,
   input  xtis_pkg::item_type                q_item,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [xtis_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_hv_relay,
   output logic                              rsp_filament_relay,
   output logic                              rsp_fault_flag,
   output logic                              rsp_fault_led,
   output logic [xtis_pkg::KV_W-1:0]         rsp_present_kv,
   output logic [xtis_pkg::KV_W-1:0]         rsp_target_kv,
   output logic [xtis_pkg::METER_W-1:0]      rsp_meter_value
);

   localparam int PROD_W = xtis_pkg::KV_W + xtis_pkg::RECIP_W;

   logic [xtis_pkg::KV_W-1:0]    target_kv_ff, target_kv_in;
   logic [xtis_pkg::KV_W-1:0]    present_kv_ff, present_kv_in;
   logic [xtis_pkg::CUR_W-1:0]   target_ua_ff, target_ua_in;
   logic                         expose_ff, expose_in;
   logic [xtis_pkg::DUR_W-1:0]   remain_ff, remain_in;
   logic                         filament_ff, filament_in;
   logic                         fault_ff, fault_in;
   logic [xtis_pkg::RAMP_W-1:0]  ramp_ff, ramp_in;
   logic [xtis_pkg::BLINK_W-1:0] blink_ff, blink_in;
   logic                         valid_ff, valid_in;
   xtis_pkg::status_type         status_ff, status_in;

   logic [xtis_pkg::DUR_W-1:0]   remain_dec;
   logic [xtis_pkg::RAMP_W:0]    ramp_next;
   logic [xtis_pkg::BLINK_W:0]   blink_next;
   logic [16:0]                  meas_scaled;
   logic [17:0]                  warn_lim;
   logic [17:0]                  trip_lim;
   logic [PROD_W-1:0]            meter_prod;

   assign q_pop = ~q_empty & (~valid_ff | ~rsp_stall);

   assign remain_dec  = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
   assign ramp_next   = {1'b0, ramp_ff} + 1'b1;
   assign blink_next  = {1'b0, blink_ff} + 1'b1;
   assign meas_scaled = 17'(q_item.meas) * 17'(xtis_pkg::PCT_SCALE);
   assign warn_lim    = 18'(target_ua_ff) * 18'(cfg.warn_pct);
   assign trip_lim    = 18'(target_ua_ff) * 18'(cfg.trip_pct);

   always_comb begin
      target_kv_in  = target_kv_ff;
      present_kv_in = present_kv_ff;
      target_ua_in  = target_ua_ff;
      expose_in     = expose_ff;
      remain_in     = remain_ff;
      filament_in   = filament_ff;
      fault_in      = fault_ff;
      ramp_in       = ramp_ff;
      blink_in      = blink_ff;
      status_in     = status_ff;
      valid_in      = valid_ff & rsp_stall;

      if (q_pop) begin
         valid_in  = 1'b1;
         status_in = xtis_pkg::ST_OK;
         case (q_item.cmd)
            xtis_pkg::CMD_TICK: begin
               if (expose_ff) begin
                  remain_in = remain_dec;
                  if (remain_dec == '0) begin
                     expose_in = 1'b0;
                     status_in = xtis_pkg::ST_TIMED_STOP;
                  end
               end
               // one kv step per ramp interval; an interval of zero acts as one
               if (present_kv_ff == target_kv_ff) begin
                  ramp_in = '0;
               end else if (ramp_next >= {1'b0, cfg.ramp_ms}) begin
                  ramp_in = '0;
                  if (present_kv_ff < target_kv_ff) begin
                     present_kv_in = present_kv_ff + 1'b1;
                  end else begin
                     present_kv_in = present_kv_ff - 1'b1;
                  end
               end else begin
                  ramp_in = ramp_next[xtis_pkg::RAMP_W-1:0];
               end
               if (blink_next >= (xtis_pkg::BLINK_W + 1)'(xtis_pkg::BLINK_PERIOD)) begin
                  blink_in = '0;
               end else begin
                  blink_in = blink_next[xtis_pkg::BLINK_W-1:0];
               end
            end
            xtis_pkg::CMD_SET_VOLT:    target_kv_in = q_item.kv;
            xtis_pkg::CMD_VOLT_REJECT: status_in    = xtis_pkg::ST_VOLT_RANGE;
            xtis_pkg::CMD_SET_CUR: begin
               target_ua_in = q_item.ua;
               filament_in  = q_item.fil_on;
            end
            xtis_pkg::CMD_CUR_REJECT:  status_in    = xtis_pkg::ST_CUR_RANGE;
            xtis_pkg::CMD_START: begin
               if (fault_ff) begin
                  status_in = xtis_pkg::ST_FAULTED;
               end else if (present_kv_ff < cfg.min_kv) begin
                  status_in = xtis_pkg::ST_VOLT_LOW;
               end else begin
                  expose_in = 1'b1;
                  remain_in = q_item.dur;
               end
            end
            xtis_pkg::CMD_STOP:        expose_in = 1'b0;
            xtis_pkg::CMD_ESTOP: begin
               expose_in    = 1'b0;
               target_kv_in = '0;
               target_ua_in = '0;
               filament_in  = 1'b0;
               fault_in     = 1'b1;
            end
            xtis_pkg::CMD_CLR_FAULT:   fault_in = 1'b0;
            xtis_pkg::CMD_MEASURE: begin
               // trip is only looked at once the warning level is passed
               if (filament_ff && (18'(meas_scaled) > warn_lim)) begin
                  if (18'(meas_scaled) > trip_lim) begin
                     expose_in    = 1'b0;
                     target_kv_in = '0;
                     target_ua_in = '0;
                     filament_in  = 1'b0;
                     fault_in     = 1'b1;
                     status_in    = xtis_pkg::ST_TRIP;
                  end else begin
                     status_in = xtis_pkg::ST_WARN;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_kv_ff  <= '0;
         present_kv_ff <= '0;
         target_ua_ff  <= '0;
         expose_ff     <= 1'b0;
         remain_ff     <= '0;
         filament_ff   <= 1'b0;
         fault_ff      <= 1'b0;
         ramp_ff       <= '0;
         blink_ff      <= '0;
         valid_ff      <= 1'b0;
         status_ff     <= xtis_pkg::ST_OK;
      end else begin
         target_kv_ff  <= target_kv_in;
         present_kv_ff <= present_kv_in;
         target_ua_ff  <= target_ua_in;
         expose_ff     <= expose_in;
         remain_ff     <= remain_in;
         filament_ff   <= filament_in;
         fault_ff      <= fault_in;
         ramp_ff       <= ramp_in;
         blink_ff      <= blink_in;
         valid_ff      <= valid_in;
         status_ff     <= status_in;
      end
   end

   // state only moves when the result slot is free, so it doubles as the result
   assign meter_prod = PROD_W'(present_kv_ff) * PROD_W'(xtis_pkg::METER_RECIP);

   always_comb begin
      if (present_kv_ff > xtis_pkg::KV_W'(xtis_pkg::FULL_SCALE_KV)) begin
         rsp_meter_value = xtis_pkg::METER_W'(xtis_pkg::METER_MAX);
      end else begin
         rsp_meter_value = meter_prod[xtis_pkg::METER_SHIFT +: xtis_pkg::METER_W];
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_hv_relay       = expose_ff;
   assign rsp_filament_relay = filament_ff;
   assign rsp_fault_flag     = fault_ff;
   assign rsp_fault_led      = fault_ff &
                               (blink_ff < xtis_pkg::BLINK_W'(xtis_pkg::BLINK_ON));
   assign rsp_present_kv     = present_kv_ff;
   assign rsp_target_kv      = target_kv_ff;

endmodule

### rtl/xray_tube_interlock_sequencer_top.sv
// top level of the x-ray tube interlock sequencer
// depends on xtis_pkg, xtis_csr, xtis_front, xtis_queue and xtis_back
//
// usage
//  - req channel: one request per tick (func 0) or command (func 1..7), taken on a
//    rising edge with req_valid high and req_stall low
//  - rsp channel: exactly one result per request, in request order, taken on a
//    rising edge with rsp_valid high and rsp_stall low; fields hold while stalled
//  - csr port: apb-style, registers at byte addresses 0,4,..,24, written in the
//    access cycle, pready tied high; write only while no request is in flight
//  - path: a taken request is written into the queue, then applied by the back end,
//    which registers its result in the result register that presents it
//  - throughput: one request per cycle while not stalled; the front end classifies
//    and range-checks, the back end applies one command per cycle while its result
//    slot is free, and the two-entry queue sets how far the front runs ahead
//  - receiver stall: the result register holds, the back end stops, the queue
//    fills and req_stall rises once both entries are taken
//  - reset (synchronous): relays open, voltages, currents, timers and fault latch
//    cleared, queue empty, registers back to their defaults
//  - meter value is formed from the registered present voltage with a scaled
//    reciprocal multiply and saturates above full scale
module xray_tube_interlock_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [xtis_pkg::FUNC_W-1:0]       req_func,
   input  logic [xtis_pkg::REQ_KV_W-1:0]     req_kilovolts,
   input  logic [xtis_pkg::CUR_W-1:0]        req_microamps,
   input  logic [xtis_pkg::DUR_W-1:0]        req_duration_ms,
   input  logic [xtis_pkg::CUR_W-1:0]        req_measured_microamps,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [xtis_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_hv_relay,
   output logic                              rsp_filament_relay,
   output logic                              rsp_fault_flag,
   output logic                              rsp_fault_led,
   output logic [xtis_pkg::KV_W-1:0]         rsp_present_kv,
   output logic [xtis_pkg::KV_W-1:0]         rsp_target_kv,
   output logic [xtis_pkg::METER_W-1:0]      rsp_meter_value,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xtis_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [xtis_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [xtis_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   xtis_pkg::cfg_type  cfg;
   xtis_pkg::item_type push_item;
   xtis_pkg::item_type pop_item;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   // register file; the user must keep it stable while requests are in flight, the block does not enforce it
   xtis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // decode and range checks
   xtis_front u_front (
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_kilovolts          (req_kilovolts),
      .req_microamps          (req_microamps),
      .req_duration_ms        (req_duration_ms),
      .req_measured_microamps (req_measured_microamps),
      .cfg                    (cfg),
      .q_full                 (q_full),
      .q_push                 (q_push),
      .q_item                 (push_item)
   );

   // decouples request acceptance from result stalls
   xtis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // tube state, timers, interlocks and result register
   xtis_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .q_empty            (q_empty),
      .q_item             (pop_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_hv_relay       (rsp_hv_relay),
      .rsp_filament_relay (rsp_filament_relay),
      .rsp_fault_flag     (rsp_fault_flag),
      .rsp_fault_led      (rsp_fault_led),
      .rsp_present_kv     (rsp_present_kv),
      .rsp_target_kv      (rsp_target_kv),
      .rsp_meter_value    (rsp_meter_value)
   );

endmodule
